/* hdl/spc_pkg.sv */
// Shared types, widths and codes for the segment plane clipper.
// Used by every module of the block; depends on nothing.
package spc_pkg;

    localparam int COORD_W   = 32;
    localparam int NORM_FRAC = 30;
    localparam int TOL_W     = 16;
    localparam int DIST_W    = 38;
    localparam int NUM_W     = DIST_W;
    localparam int DEN_W     = DIST_W + 1;
    localparam int MAG_W     = COORD_W;
    localparam int PROD_W    = MAG_W + NUM_W;
    localparam int SPLIT_W   = NUM_W / 2;
    localparam int QUO_W     = COORD_W;
    localparam int SUM_W     = 2 * COORD_W + 2;
    localparam int CFG_IDX_W = 3;
    localparam int STAGES    = 2 + 3 + QUO_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd4;

    localparam logic [COORD_W-1:0] NORMAL_Z_RST = 32'h4000_0000;
    localparam logic [TOL_W-1:0]   TOL_RST      = 16'd1;

    localparam logic [2:0] MODE_KEEP   = 3'd0;
    localparam logic [2:0] MODE_BOTH_S = 3'd1;
    localparam logic [2:0] MODE_BOTH_E = 3'd2;
    localparam logic [2:0] MODE_MOVE_S = 3'd3;
    localparam logic [2:0] MODE_MOVE_E = 3'd4;

    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_POINT = 2'd1;
    localparam logic [1:0] CLS_SPAN  = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nz;
        logic signed [COORD_W-1:0] off;
        logic [TOL_W-1:0]          tol;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] sz;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
        logic signed [COORD_W-1:0] ez;
        logic [2:0]                mode;
        logic [1:0]                cls;
    } t_seg;

    typedef struct packed {
        logic [2:0]                  neg;
        logic [DEN_W-1:0]            den;
        logic [2:0][DEN_W-1:0]       rem;
        logic [2:0][QUO_W-1:0]       quo;
    } t_div;

endpackage

/* hdl/spc_dist.sv */
// Signed plane distance of both endpoints: products, then sum and offset.
// Two register stages; depends on spc_pkg.
module spc_dist (
    input  logic                          i_clk,
    input  logic [1:0]                    i_en,
    input  spc_pkg::t_cfg                 i_cfg,
    input  spc_pkg::t_seg                 i_seg,
    output spc_pkg::t_seg                 o_seg,
    output logic signed [spc_pkg::DIST_W-1:0] o_d1,
    output logic signed [spc_pkg::DIST_W-1:0] o_d2
);

    spc_pkg::t_seg r_seg1;
    spc_pkg::t_seg r_seg2;
    logic signed [2*spc_pkg::COORD_W-1:0] r_p [6];
    logic signed [spc_pkg::DIST_W-1:0] r_d1;
    logic signed [spc_pkg::DIST_W-1:0] r_d2;
    logic signed [spc_pkg::SUM_W-1:0] sum1;
    logic signed [spc_pkg::SUM_W-1:0] sum2;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_seg1 <= i_seg;
            r_p[0] <= (2*spc_pkg::COORD_W)'(i_cfg.nx) * (2*spc_pkg::COORD_W)'(i_seg.sx);
            r_p[1] <= (2*spc_pkg::COORD_W)'(i_cfg.ny) * (2*spc_pkg::COORD_W)'(i_seg.sy);
            r_p[2] <= (2*spc_pkg::COORD_W)'(i_cfg.nz) * (2*spc_pkg::COORD_W)'(i_seg.sz);
            r_p[3] <= (2*spc_pkg::COORD_W)'(i_cfg.nx) * (2*spc_pkg::COORD_W)'(i_seg.ex);
            r_p[4] <= (2*spc_pkg::COORD_W)'(i_cfg.ny) * (2*spc_pkg::COORD_W)'(i_seg.ey);
            r_p[5] <= (2*spc_pkg::COORD_W)'(i_cfg.nz) * (2*spc_pkg::COORD_W)'(i_seg.ez);
        end
    end

    always_comb begin
        sum1 = spc_pkg::SUM_W'(r_p[0]) + spc_pkg::SUM_W'(r_p[1]) + spc_pkg::SUM_W'(r_p[2]);
        sum2 = spc_pkg::SUM_W'(r_p[3]) + spc_pkg::SUM_W'(r_p[4]) + spc_pkg::SUM_W'(r_p[5]);
    end

    // Arithmetic shift gives the floor of the Q1.30 scaling.
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_seg2 <= r_seg1;
            r_d1   <= spc_pkg::DIST_W'(sum1 >>> spc_pkg::NORM_FRAC)
                      + spc_pkg::DIST_W'(i_cfg.off);
            r_d2   <= spc_pkg::DIST_W'(sum2 >>> spc_pkg::NORM_FRAC)
                      + spc_pkg::DIST_W'(i_cfg.off);
        end
    end

    assign o_seg = r_seg2;
    assign o_d1  = r_d1;
    assign o_d2  = r_d2;

endmodule

/* hdl/spc_setup.sv */
// Classifies endpoints, picks the output case and forms the divider operands.
// Three register stages; depends on spc_pkg.
module spc_setup (
    input  logic                              i_clk,
    input  logic [2:0]                        i_en,
    input  logic [spc_pkg::TOL_W-1:0]         i_tol,
    input  spc_pkg::t_seg                     i_seg,
    input  logic signed [spc_pkg::DIST_W-1:0] i_d1,
    input  logic signed [spc_pkg::DIST_W-1:0] i_d2,
    output spc_pkg::t_seg                     o_seg,
    output spc_pkg::t_div                     o_div
);

    logic signed [spc_pkg::DIST_W-1:0] tol_s;
    logic below1, above1, below2, above2;
    logic signed [spc_pkg::DEN_W-1:0] dd;
    logic signed [spc_pkg::COORD_W:0] diff [3];
    spc_pkg::t_seg seg_c;

    spc_pkg::t_seg r_seg3, r_seg4, r_seg5;
    logic [spc_pkg::NUM_W-1:0] r_num;
    logic [spc_pkg::DEN_W-1:0] r_den3, r_den4;
    logic [2:0] r_neg3, r_neg4;
    logic [spc_pkg::MAG_W-1:0] r_mag [3];
    logic [spc_pkg::MAG_W+spc_pkg::SPLIT_W-1:0] r_pl [3];
    logic [spc_pkg::MAG_W+spc_pkg::SPLIT_W-1:0] r_ph [3];
    spc_pkg::t_div r_div;
    logic [spc_pkg::PROD_W-1:0] prod [3];

    always_comb begin
        tol_s  = {{(spc_pkg::DIST_W-spc_pkg::TOL_W){1'b0}}, i_tol};
        below1 = i_d1 < -tol_s;
        above1 = i_d1 > tol_s;
        below2 = i_d2 < -tol_s;
        above2 = i_d2 > tol_s;
        dd     = spc_pkg::DEN_W'(i_d1) - spc_pkg::DEN_W'(i_d2);
        diff[0] = (spc_pkg::COORD_W+1)'(i_seg.ex) - (spc_pkg::COORD_W+1)'(i_seg.sx);
        diff[1] = (spc_pkg::COORD_W+1)'(i_seg.ey) - (spc_pkg::COORD_W+1)'(i_seg.sy);
        diff[2] = (spc_pkg::COORD_W+1)'(i_seg.ez) - (spc_pkg::COORD_W+1)'(i_seg.sz);
        seg_c  = i_seg;
        if (below1) begin
            if (below2) begin
                seg_c.mode = spc_pkg::MODE_BOTH_S;
                seg_c.cls  = spc_pkg::CLS_NONE;
            end else if (above2) begin
                seg_c.mode = spc_pkg::MODE_MOVE_S;
                seg_c.cls  = spc_pkg::CLS_SPAN;
            end else begin
                seg_c.mode = spc_pkg::MODE_BOTH_E;
                seg_c.cls  = spc_pkg::CLS_POINT;
            end
        end else if (above1) begin
            seg_c.mode = below2 ? spc_pkg::MODE_MOVE_E : spc_pkg::MODE_KEEP;
            seg_c.cls  = spc_pkg::CLS_SPAN;
        end else begin
            seg_c.mode = below2 ? spc_pkg::MODE_BOTH_S : spc_pkg::MODE_KEEP;
            seg_c.cls  = above2 ? spc_pkg::CLS_SPAN : spc_pkg::CLS_POINT;
        end
    end

    // In both crossing cases the weight is |d1| / |d1 - d2|.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_seg3 <= seg_c;
            r_num  <= i_d1[spc_pkg::DIST_W-1] ? spc_pkg::NUM_W'(-i_d1)
                                              : spc_pkg::NUM_W'(i_d1);
            r_den3 <= dd[spc_pkg::DEN_W-1] ? spc_pkg::DEN_W'(-dd) : spc_pkg::DEN_W'(dd);
            for (int a = 0; a < 3; a++) begin
                r_neg3[a] <= diff[a][spc_pkg::COORD_W];
                r_mag[a]  <= diff[a][spc_pkg::COORD_W] ? spc_pkg::MAG_W'(-diff[a])
                                                       : spc_pkg::MAG_W'(diff[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_seg4 <= r_seg3;
            r_den4 <= r_den3;
            r_neg4 <= r_neg3;
            for (int a = 0; a < 3; a++) begin
                r_pl[a] <= (spc_pkg::MAG_W+spc_pkg::SPLIT_W)'(r_mag[a])
                           * (spc_pkg::MAG_W+spc_pkg::SPLIT_W)'(
                                 r_num[spc_pkg::SPLIT_W-1:0]);
                r_ph[a] <= (spc_pkg::MAG_W+spc_pkg::SPLIT_W)'(r_mag[a])
                           * (spc_pkg::MAG_W+spc_pkg::SPLIT_W)'(
                                 r_num[spc_pkg::NUM_W-1:spc_pkg::SPLIT_W]);
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            prod[a] = spc_pkg::PROD_W'(r_pl[a])
                      + (spc_pkg::PROD_W'(r_ph[a]) << spc_pkg::SPLIT_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_seg5      <= r_seg4;
            r_div.den   <= r_den4;
            r_div.neg   <= r_neg4;
            for (int a = 0; a < 3; a++) begin
                r_div.rem[a] <= spc_pkg::DEN_W'(prod[a][spc_pkg::PROD_W-1:spc_pkg::QUO_W]);
                r_div.quo[a] <= prod[a][spc_pkg::QUO_W-1:0];
            end
        end
    end

    assign o_seg = r_seg5;
    assign o_div = r_div;

endmodule

/* hdl/spc_div_step.sv */
// One restoring division step for the three axes, with its register stage.
// Depends on spc_pkg.
module spc_div_step (
    input  logic          i_clk,
    input  logic          i_en,
    input  spc_pkg::t_seg i_seg,
    input  spc_pkg::t_div i_div,
    output spc_pkg::t_seg o_seg,
    output spc_pkg::t_div o_div
);

    spc_pkg::t_seg r_seg;
    spc_pkg::t_div r_div;
    spc_pkg::t_div n_div;
    logic [spc_pkg::DEN_W:0] t;
    logic ge;

    always_comb begin
        n_div = i_div;
        t     = '0;
        ge    = 1'b0;
        for (int a = 0; a < 3; a++) begin
            t  = {i_div.rem[a], i_div.quo[a][spc_pkg::QUO_W-1]};
            ge = t >= {1'b0, i_div.den};
            n_div.rem[a] = ge ? spc_pkg::DEN_W'(t - {1'b0, i_div.den})
                              : t[spc_pkg::DEN_W-1:0];
            n_div.quo[a] = {i_div.quo[a][spc_pkg::QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_seg <= i_seg;
            r_div <= n_div;
        end
    end

    assign o_seg = r_seg;
    assign o_div = r_div;

endmodule

/* hdl/segment_plane_clipper_core.sv */
// Top level of the segment plane clipper: config registers, stage control,
// final interpolation and output register. Depends on spc_pkg and all submodules.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------
//  input   | i_valid / o_stall          | i_start_*, i_end_*
//  output  | o_valid / i_stall          | o_kept_start_*, o_kept_end_*, o_clip_class
//  config  | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One segment can be taken every cycle while no stall holds the pipeline. In order, it has
// stages for the distance, for setup and the wide product, for the quotient bits
// (one per stage) and the output register.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up under output stall. Synchronous active-low reset clears
// the valid bits and sets the configuration registers to their reset values.
module segment_plane_clipper_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [spc_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [spc_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [spc_pkg::COORD_W-1:0] i_start_z,
    input  logic signed [spc_pkg::COORD_W-1:0] i_end_x,
    input  logic signed [spc_pkg::COORD_W-1:0] i_end_y,
    input  logic signed [spc_pkg::COORD_W-1:0] i_end_z,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [spc_pkg::COORD_W-1:0] o_kept_start_x,
    output logic signed [spc_pkg::COORD_W-1:0] o_kept_start_y,
    output logic signed [spc_pkg::COORD_W-1:0] o_kept_start_z,
    output logic signed [spc_pkg::COORD_W-1:0] o_kept_end_x,
    output logic signed [spc_pkg::COORD_W-1:0] o_kept_end_y,
    output logic signed [spc_pkg::COORD_W-1:0] o_kept_end_z,
    output logic [1:0]                         o_clip_class,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [spc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [spc_pkg::COORD_W-1:0]        i_cfg_data
);

    localparam int DIV0 = 5;
    localparam int LAST = spc_pkg::STAGES - 1;

    spc_pkg::t_cfg r_cfg;
    logic [spc_pkg::STAGES-1:0] r_vld;
    logic [spc_pkg::STAGES-1:0] en;
    spc_pkg::t_seg in_seg;
    spc_pkg::t_seg dist_seg;
    logic signed [spc_pkg::DIST_W-1:0] d1, d2;
    spc_pkg::t_seg w_seg [spc_pkg::QUO_W+1];
    spc_pkg::t_div w_div [spc_pkg::QUO_W+1];
    spc_pkg::t_seg fs;
    spc_pkg::t_div fd;
    logic [spc_pkg::COORD_W-1:0] mv [3];
    logic [spc_pkg::COORD_W-1:0] sv [3];
    logic [spc_pkg::COORD_W-1:0] ev [3];
    logic [2:0][spc_pkg::COORD_W-1:0] n_ks, n_ke;
    logic [2:0][spc_pkg::COORD_W-1:0] r_ks, r_ke;
    logic [1:0] r_cls;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nx  <= '0;
            r_cfg.ny  <= '0;
            r_cfg.nz  <= spc_pkg::NORMAL_Z_RST;
            r_cfg.off <= '0;
            r_cfg.tol <= spc_pkg::TOL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                spc_pkg::REG_NORMAL_X:  r_cfg.nx  <= i_cfg_data;
                spc_pkg::REG_NORMAL_Y:  r_cfg.ny  <= i_cfg_data;
                spc_pkg::REG_NORMAL_Z:  r_cfg.nz  <= i_cfg_data;
                spc_pkg::REG_OFFSET:    r_cfg.off <= i_cfg_data;
                spc_pkg::REG_TOLERANCE: r_cfg.tol <= i_cfg_data[spc_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        en[LAST] = !r_vld[LAST] || !i_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < spc_pkg::STAGES; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_comb begin
        in_seg.sx   = i_start_x;
        in_seg.sy   = i_start_y;
        in_seg.sz   = i_start_z;
        in_seg.ex   = i_end_x;
        in_seg.ey   = i_end_y;
        in_seg.ez   = i_end_z;
        in_seg.mode = spc_pkg::MODE_KEEP;
        in_seg.cls  = spc_pkg::CLS_NONE;
    end

    spc_dist u_dist (
        .i_clk (i_clk),
        .i_en  (en[1:0]),
        .i_cfg (r_cfg),
        .i_seg (in_seg),
        .o_seg (dist_seg),
        .o_d1  (d1),
        .o_d2  (d2)
    );

    spc_setup u_setup (
        .i_clk (i_clk),
        .i_en  (en[DIV0-1:2]),
        .i_tol (r_cfg.tol),
        .i_seg (dist_seg),
        .i_d1  (d1),
        .i_d2  (d2),
        .o_seg (w_seg[0]),
        .o_div (w_div[0])
    );

    for (genvar g = 0; g < spc_pkg::QUO_W; g++) begin : g_div
        spc_div_step u_step (
            .i_clk (i_clk),
            .i_en  (en[DIV0+g]),
            .i_seg (w_seg[g]),
            .i_div (w_div[g]),
            .o_seg (w_seg[g+1]),
            .o_div (w_div[g+1])
        );
    end

    assign fs = w_seg[spc_pkg::QUO_W];
    assign fd = w_div[spc_pkg::QUO_W];

    // A negative step rounds toward minus infinity: one more when inexact.
    always_comb begin
        sv[0] = fs.sx;  sv[1] = fs.sy;  sv[2] = fs.sz;
        ev[0] = fs.ex;  ev[1] = fs.ey;  ev[2] = fs.ez;
        for (int a = 0; a < 3; a++) begin
            mv[a] = fd.neg[a]
                  ? sv[a] - fd.quo[a] - {{(spc_pkg::COORD_W-1){1'b0}}, (fd.rem[a] != '0)}
                  : sv[a] + fd.quo[a];
        end
        for (int a = 0; a < 3; a++) begin
            case (fs.mode)
                spc_pkg::MODE_BOTH_S: begin n_ks[a] = sv[a]; n_ke[a] = sv[a]; end
                spc_pkg::MODE_BOTH_E: begin n_ks[a] = ev[a]; n_ke[a] = ev[a]; end
                spc_pkg::MODE_MOVE_S: begin n_ks[a] = mv[a]; n_ke[a] = ev[a]; end
                spc_pkg::MODE_MOVE_E: begin n_ks[a] = sv[a]; n_ke[a] = mv[a]; end
                default:              begin n_ks[a] = sv[a]; n_ke[a] = ev[a]; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[LAST]) begin
            r_ks  <= n_ks;
            r_ke  <= n_ke;
            r_cls <= fs.cls;
        end
    end

    assign o_valid        = r_vld[LAST];
    assign o_kept_start_x = r_ks[0];
    assign o_kept_start_y = r_ks[1];
    assign o_kept_start_z = r_ks[2];
    assign o_kept_end_x   = r_ke[0];
    assign o_kept_end_y   = r_ke[1];
    assign o_kept_end_z   = r_ke[2];
    assign o_clip_class   = r_cls;

    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_clip_class != 2'd3))
        else $error("clip class out of range");

    a_none_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clip_class == spc_pkg::CLS_NONE) |-> (r_ks == r_ke))
        else $error("empty result with differing endpoints");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST-1] && (fs.mode == spc_pkg::MODE_MOVE_S
                           || fs.mode == spc_pkg::MODE_MOVE_E))
        |-> (fd.rem[0] < fd.den && fd.rem[1] < fd.den && fd.rem[2] < fd.den))
        else $error("divider remainder not below divisor");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[LAST-1] && !en[LAST]) |=> r_vld[LAST-1])
        else $error("pending item dropped before output stage");

endmodule

/* tb/tb_segment_plane_clipper_core.sv */
// Self-checking testbench for segment_plane_clipper_core: directed, plane sweep,
// random and backpressure tests against an exact in-bench predictor.
// Depends on spc_pkg and segment_plane_clipper_core.
module tb_segment_plane_clipper_core;

    localparam int IDLE_LIMIT   = 8000;
    localparam int DRAIN_CYCLES = 45;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic signed [31:0] sx, sy, sz, ex, ey, ez;
    } t_segment;

    typedef struct packed {
        logic [31:0] ksx, ksy, ksz, kex, key, kez;
        logic [1:0]  cls;
    } t_clip;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic signed [31:0] i_start_x = '0, i_start_y = '0, i_start_z = '0;
    logic signed [31:0] i_end_x = '0, i_end_y = '0, i_end_z = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic signed [31:0] o_kept_start_x, o_kept_start_y, o_kept_start_z;
    logic signed [31:0] o_kept_end_x, o_kept_end_y, o_kept_end_z;
    logic [1:0]  o_clip_class;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [spc_pkg::CFG_IDX_W-1:0] i_cfg_index = spc_pkg::REG_NORMAL_X;
    logic [31:0] i_cfg_data = '0;

    segment_plane_clipper_core dut (.*);

    always #4 i_clk = ~i_clk;

    // Plane currently held by the block, mirrored at each register transfer.
    logic signed [31:0] pl_nx, pl_ny, pl_nz, pl_off;
    logic [15:0]        pl_tol;

    t_clip pending_clips[$];
    int    mismatches = 0;
    int    segs_sent = 0;
    int    clips_seen = 0;
    int    class_count[3] = '{0, 0, 0};
    int    idle_cycles = 0;
    int    hold_request = 0;

    function automatic logic signed [127:0] plane_dist(logic signed [31:0] x, y, z);
        logic signed [127:0] a, b, c, px, py, pz, o, acc;
        a = pl_nx; b = pl_ny; c = pl_nz; o = pl_off;
        px = x; py = y; pz = z;
        acc = a * px + b * py + c * pz;
        return (acc >>> spc_pkg::NORM_FRAC) + o;
    endfunction

    function automatic int side_of(logic signed [127:0] d);
        logic signed [127:0] t;
        t = {112'b0, pl_tol};
        if (d < -t) return -1;
        if (d > t) return 1;
        return 0;
    endfunction

    // Point a + floor((b - a) * num / den), wrapped to the coordinate width.
    function automatic logic [31:0] move_coord(logic signed [31:0] a, b,
                                               logic signed [127:0] num, den);
        logic signed [127:0] wa, wb, p, q;
        wa = a; wb = b;
        p = (wb - wa) * num;
        q = p / den;
        if (p % den != 0 && p < 0) q = q - 1;
        return 32'(wa + q);
    endfunction

    function automatic t_clip clip_segment(t_segment g);
        t_clip r;
        logic signed [127:0] d1, d2;
        int c1, c2;
        d1 = plane_dist(g.sx, g.sy, g.sz);
        d2 = plane_dist(g.ex, g.ey, g.ez);
        c1 = side_of(d1);
        c2 = side_of(d2);
        r = '{g.sx, g.sy, g.sz, g.ex, g.ey, g.ez, spc_pkg::CLS_SPAN};
        if (c1 < 0 && c2 < 0) begin
            r = '{g.sx, g.sy, g.sz, g.sx, g.sy, g.sz, spc_pkg::CLS_NONE};
        end else if (c1 < 0 && c2 > 0) begin
            r.ksx = move_coord(g.sx, g.ex, -d1, d2 - d1);
            r.ksy = move_coord(g.sy, g.ey, -d1, d2 - d1);
            r.ksz = move_coord(g.sz, g.ez, -d1, d2 - d1);
        end else if (c1 < 0) begin
            r = '{g.ex, g.ey, g.ez, g.ex, g.ey, g.ez, spc_pkg::CLS_POINT};
        end else if (c1 > 0 && c2 < 0) begin
            r.kex = move_coord(g.sx, g.ex, d1, d1 - d2);
            r.key = move_coord(g.sy, g.ey, d1, d1 - d2);
            r.kez = move_coord(g.sz, g.ez, d1, d1 - d2);
        end else if (c1 == 0 && c2 < 0) begin
            r = '{g.sx, g.sy, g.sz, g.sx, g.sy, g.sz, spc_pkg::CLS_POINT};
        end else if (c1 == 0 && c2 == 0) begin
            r.cls = spc_pkg::CLS_POINT;
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_clip want;
        if (i_rst_n && o_valid && !i_stall) begin
            clips_seen++;
            if (pending_clips.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) $display("mismatch: result with none expected");
            end else begin
                want = pending_clips.pop_front();
                check_field("kept_start_x", want.ksx, o_kept_start_x);
                check_field("kept_start_y", want.ksy, o_kept_start_y);
                check_field("kept_start_z", want.ksz, o_kept_start_z);
                check_field("kept_end_x", want.kex, o_kept_end_x);
                check_field("kept_end_y", want.key, o_kept_end_y);
                check_field("kept_end_z", want.kez, o_kept_end_z);
                check_field("clip_class", 32'(want.cls), 32'(o_clip_class));
                if (want.cls <= spc_pkg::CLS_SPAN) class_count[want.cls]++;
            end
        end
    end

    // Receiver stalls: runs of random length, a forced long stretch on request.
    int run_left = 0;
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            run_left <= hold_request;
            hold_request = 0;
            i_stall <= 1'b1;
        end else if (run_left > 0) begin
            run_left <= run_left - 1;
        end else if ($urandom_range(0, 9) < 3) begin
            i_stall <= 1'b1;
            run_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(0, 3);
        end else begin
            i_stall <= 1'b0;
            run_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(20, 100)
                                                    : $urandom_range(0, 4);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("segment_plane_clipper_core test failed");
            $finish;
        end
    end

    task automatic send_segment(t_segment g, bit no_gap = 0);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        gap = (no_gap || pick < 65) ? 0 : (pick < 95) ? $urandom_range(1, 3)
                                                      : $urandom_range(10, 40);
        repeat (gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_start_x, i_start_y, i_start_z, i_end_x, i_end_y, i_end_z} <= g;
        do @(posedge i_clk); while (o_stall);
        pending_clips.push_back(clip_segment(g));
        segs_sent++;
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (pending_clips.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [spc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            spc_pkg::REG_NORMAL_X:  pl_nx = val;
            spc_pkg::REG_NORMAL_Y:  pl_ny = val;
            spc_pkg::REG_NORMAL_Z:  pl_nz = val;
            spc_pkg::REG_OFFSET:    pl_off = val;
            spc_pkg::REG_TOLERANCE: pl_tol = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_plane(logic [31:0] nx, ny, nz, off, tol);
        drain();
        write_reg(spc_pkg::REG_NORMAL_X, nx);
        write_reg(spc_pkg::REG_NORMAL_Y, ny);
        write_reg(spc_pkg::REG_NORMAL_Z, nz);
        write_reg(spc_pkg::REG_OFFSET, off);
        write_reg(spc_pkg::REG_TOLERANCE, tol);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        logic [31:0] edges[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return edges[$urandom_range(0, 3)];
            3, 4, 5: return 32'($urandom_range(0, 2 ** 21)) - 32'(2 ** 20);
            default: return 32'($urandom_range(0, 16)) - 32'd8;
        endcase
    endfunction

    // Mostly short segments around a random point, so both sides and the band occur.
    function automatic t_segment rand_segment();
        t_segment g;
        g.sx = rand_coord(); g.sy = rand_coord(); g.sz = rand_coord();
        if ($urandom_range(0, 3) == 0) begin
            g.ex = rand_coord(); g.ey = rand_coord(); g.ez = rand_coord();
        end else begin
            g.ex = g.sx + rand_coord(); g.ey = g.sy + rand_coord(); g.ez = g.sz + rand_coord();
        end
        return g;
    endfunction

    task automatic random_plane();
        logic [31:0] n[3];
        int axis;
        axis = $urandom_range(0, 2);
        foreach (n[k]) begin
            case ($urandom_range(0, 5))
                0:       n[k] = $urandom;
                1, 2:    n[k] = 32'($urandom_range(0, 2 ** 31)) - 32'(2 ** 30);
                default: n[k] = (k == axis) ? ($urandom_range(0, 1) ? 32'h4000_0000
                                                                    : 32'hc000_0000) : 32'h0;
            endcase
        end
        set_plane(n[0], n[1], n[2],
                  $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 2 ** 20)) - 32'(2 ** 19),
                  $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 8));
    endtask

    task automatic test_directed;
        logic signed [31:0] zs[4] = '{-32'sd65536, 32'sd65536, 32'sd1, 32'sd0};
        int k;
        // Reset plane: z up, offset zero, band of one step.
        pl_nx = 0; pl_ny = 0; pl_nz = spc_pkg::NORMAL_Z_RST; pl_off = 0;
        pl_tol = spc_pkg::TOL_RST;
        for (int a = 0; a < 4; a++)
            for (k = 0; k < 4; k++)
                send_segment('{32'sd100 * a, -32'sd77 * k, zs[a], 32'sd5 - k, 32'sd9, zs[k]});
        send_segment('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        send_segment('{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                       32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
        send_segment('{32'h0, 32'hffff_ffff, 32'sd2, 32'hffff_ffff, 32'h0, -32'sd2});
        send_segment('{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
    endtask

    task automatic test_plane_extremes;
        logic [31:0] planes[6][5] = '{
            '{32'h4000_0000, 32'h0, 32'h0, 32'hfffb_0000, 32'h0},
            '{32'hc000_0000, 32'hc000_0000, 32'hc000_0000, 32'h8000_0000, 32'hffff},
            '{32'h0, 32'h4000_0000, 32'h0, 32'h7fff_ffff, 32'h0},
            '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff},
            '{32'h2000_0000, 32'hd000_0000, 32'h1000_0000, 32'h0001_8000, 32'h1000},
            '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0}
        };
        foreach (planes[p]) begin
            set_plane(planes[p][0], planes[p][1], planes[p][2], planes[p][3], planes[p][4]);
            repeat (40) send_segment(rand_segment());
        end
    endtask

    task automatic test_random;
        for (int p = 0; p < 8; p++) begin
            random_plane();
            repeat (110) send_segment(rand_segment());
        end
    endtask

    task automatic test_backpressure;
        random_plane();
        @(posedge i_clk);
        hold_request = 300;
        repeat (120) send_segment(rand_segment(), 1);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_plane_extremes();
        test_random();
        test_backpressure();
        set_plane(32'h0, 32'h0, spc_pkg::NORMAL_Z_RST, 32'h0, 32'(spc_pkg::TOL_RST));
        repeat (60) send_segment(rand_segment());
        drain();
        if (pending_clips.size() != 0) mismatches++;
        $display("Sent %0d segments, checked %0d results over 17 plane settings.",
                 segs_sent, clips_seen);
        $display("Classes seen: none %0d, point %0d, span %0d; mismatches %0d.",
                 class_count[0], class_count[1], class_count[2], mismatches);
        if (mismatches == 0)
            $display("segment_plane_clipper_core test passed");
        else
            $display("segment_plane_clipper_core test failed");
        $finish;
    end
endmodule

/* files.f */
hdl/spc_pkg.sv
hdl/spc_dist.sv
hdl/spc_setup.sv
hdl/spc_div_step.sv
hdl/segment_plane_clipper_core.sv
tb/tb_segment_plane_clipper_core.sv
